// File: hdl/wir_pkg.sv
package wir_pkg;

   // Default store depth; the top level takes it as a parameter.
   localparam int MAX_PARTICLES_DEFAULT = 1024;

   // Fixed field widths.
   localparam int SUM_BITS    = 42;
   localparam int WEIGHT_PORT = 32;

   // Weight scale: only the low WEIGHT_BITS bits of the weight port count.
   localparam int WEIGHT_BITS = 32;
   localparam logic [WEIGHT_PORT-1:0] WEIGHT_MASK = (WEIGHT_BITS >= WEIGHT_PORT) ?
      {WEIGHT_PORT{1'b1}} : WEIGHT_PORT'((64'd1 << WEIGHT_BITS) - 64'd1);

   // Operation codes.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DRAW = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Search token handed from cell to cell.
   typedef struct packed {
      logic                valid;
      logic [SUM_BITS-1:0] value;
   } search_type;

   // Prefix write broadcast to all cells.
   typedef struct packed {
      logic                en;
      logic [SUM_BITS-1:0] data;
   } write_type;

endpackage

// File: hdl/wir_cell.sv
// One level of the search: owns the prefixes whose index has its lowest set
// bit at LEVEL, and decides that index bit for the token passing through.
module wir_cell #(
   parameter int LEVEL      = 0,
   parameter int INDEX_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wir_pkg::search_type    search_in,
   input  logic [INDEX_BITS-1:0]  idx_in,
   input  logic [INDEX_BITS:0]    count,
   input  wir_pkg::write_type     wr,
   input  logic [INDEX_BITS-1:0]  wr_idx,
   output wir_pkg::search_type    search_out,
   output logic [INDEX_BITS-1:0]  idx_out
);

   localparam int ADDR_BITS = (INDEX_BITS - LEVEL - 1 > 0) ? INDEX_BITS - LEVEL - 1 : 1;
   localparam int DEPTH     = 1 << ADDR_BITS;
   localparam logic [INDEX_BITS-1:0] LEVEL_BIT = INDEX_BITS'(1) << LEVEL;
   localparam logic [INDEX_BITS-1:0] LOW_MASK  = LEVEL_BIT | (LEVEL_BIT - INDEX_BITS'(1));

   logic [wir_pkg::SUM_BITS-1:0] prefix_mem [DEPTH];

   logic [INDEX_BITS-1:0]        rd_shift;
   logic [INDEX_BITS-1:0]        wr_shift;
   logic [ADDR_BITS-1:0]         rd_addr;
   logic [ADDR_BITS-1:0]         wr_addr;
   logic                         wr_hit;
   logic [INDEX_BITS-1:0]        cand;
   logic                         in_range;

   logic                         valid_ff;
   logic [wir_pkg::SUM_BITS-1:0] value_ff;
   logic [INDEX_BITS-1:0]        cand_ff;
   logic                         range_ff;
   logic [wir_pkg::SUM_BITS-1:0] rdata_ff;
   logic                         take;

   assign rd_shift = idx_in >> (LEVEL + 1);
   assign wr_shift = wr_idx >> (LEVEL + 1);
   assign rd_addr  = rd_shift[ADDR_BITS-1:0];
   assign wr_addr  = wr_shift[ADDR_BITS-1:0];
   assign wr_hit   = wr.en && ((wr_idx & LOW_MASK) == LEVEL_BIT);
   assign cand     = idx_in | LEVEL_BIT;
   assign in_range = {1'b0, cand} < count;

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         prefix_mem[wr_addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= search_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (search_in.valid) begin
         value_ff <= search_in.value;
         cand_ff  <= cand;
         range_ff <= in_range;
         rdata_ff <= prefix_mem[rd_addr];
      end
   end

   // Keep the bit only if the candidate is loaded and its prefix is below the draw.
   assign take              = range_ff && (rdata_ff < value_ff);
   assign search_out.valid  = valid_ff;
   assign search_out.value  = value_ff;
   assign idx_out           = take ? cand_ff : (cand_ff & ~LEVEL_BIT);

endmodule

// File: hdl/weighted_index_resampler_top.sv
// Weighted index resampler (multinomial resampling by inverse cumulative weight).
// Input channel: start/busy command port. A transfer happens on a clock edge with
// start high and busy low; req_op selects a load (one weight) or a draw.
// Loads append the exclusive prefix sum of the current set to the store and
// update the running total; req_first restarts the set. A load's result strobes
// on rsp_valid in the very next cycle, so loads may be issued every cycle
// while busy is low. A draw runs a bit-by-bit search down a chain of
// INDEX_BITS cells, one index bit per cell, each cell reading its own slice
// of the prefix store. The token passes the registers of every cell, then the
// result register, before the result strobes; busy stays high until the cycle
// of the strobe, so a new transfer waits until the draw has finished.
// Results are shown for exactly one cycle; the receiver cannot stall them.
// Reset clears the particle count, the total and all pending work; store
// contents are not cleared; only prefixes below the current count steer a draw.
module weighted_index_resampler_top #(
   parameter int MAX_PARTICLES = wir_pkg::MAX_PARTICLES_DEFAULT,
   localparam int INDEX_BITS   = $clog2(MAX_PARTICLES)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_op,
   input  logic                            req_first,
   input  logic [wir_pkg::WEIGHT_PORT-1:0] req_weight,
   input  logic [wir_pkg::SUM_BITS-1:0]    req_draw_value,
   output logic                            rsp_valid,
   output logic [INDEX_BITS-1:0]           rsp_selected_index,
   output logic [wir_pkg::SUM_BITS-1:0]    rsp_running_total,
   output logic [INDEX_BITS:0]             rsp_loaded_count,
   output logic [1:0]                      rsp_status
);

   localparam logic [INDEX_BITS:0] COUNT_FULL = (INDEX_BITS + 1)'(MAX_PARTICLES);

   // Set state
   logic [INDEX_BITS:0]             count_ff, count_in;
   logic [wir_pkg::SUM_BITS-1:0]    total_ff, total_in;
   logic                            pending_ff, pending_in;

   // Result registers
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [INDEX_BITS-1:0]           rsp_index_ff, rsp_index_in;
   wir_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [wir_pkg::SUM_BITS-1:0]    rsp_total_ff, rsp_total_in;
   logic [INDEX_BITS:0]             rsp_count_ff, rsp_count_in;

   logic                            accept;
   logic [INDEX_BITS:0]             count_base;
   logic [wir_pkg::SUM_BITS-1:0]    total_base;
   logic                            full;
   logic [wir_pkg::SUM_BITS:0]      sum_wide;
   logic [wir_pkg::SUM_BITS-1:0]    sum_sat;

   wir_pkg::write_type              wr;
   logic [INDEX_BITS-1:0]           wr_idx;

   // Cell chain links: link 0 enters the top cell, link INDEX_BITS leaves cell 0.
   wir_pkg::search_type             search_link [INDEX_BITS+1];
   logic [INDEX_BITS-1:0]           idx_link    [INDEX_BITS+1];

   assign busy   = pending_ff;
   assign accept = start && !pending_ff;

   // Load path: optional restart, overflow-saturating total.
   always_comb begin
      count_base = req_first ? '0 : count_ff;
      total_base = req_first ? '0 : total_ff;
      full       = count_base >= COUNT_FULL;
      sum_wide   = {1'b0, total_base} +
                   (wir_pkg::SUM_BITS + 1)'(req_weight & wir_pkg::WEIGHT_MASK);
      sum_sat    = sum_wide[wir_pkg::SUM_BITS] ? '1 : sum_wide[wir_pkg::SUM_BITS-1:0];
   end

   assign wr.en   = accept && (req_op == wir_pkg::OP_LOAD) && !full;
   assign wr.data = total_base;
   assign wr_idx  = count_base[INDEX_BITS-1:0];

   assign search_link[0].valid = accept && (req_op == wir_pkg::OP_DRAW);
   assign search_link[0].value = req_draw_value;
   assign idx_link[0]          = '0;

   for (genvar s = 0; s < INDEX_BITS; s++) begin : g_cell
      wir_cell #(
         .LEVEL      (INDEX_BITS - 1 - s),
         .INDEX_BITS (INDEX_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .search_in  (search_link[s]),
         .idx_in     (idx_link[s]),
         .count      (count_ff),
         .wr         (wr),
         .wr_idx     (wr_idx),
         .search_out (search_link[s+1]),
         .idx_out    (idx_link[s+1])
      );
   end

   always_comb begin
      count_in      = count_ff;
      total_in      = total_ff;
      pending_in    = pending_ff;
      rsp_valid_in  = 1'b0;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_count_in  = rsp_count_ff;

      if (accept && (req_op == wir_pkg::OP_LOAD)) begin
         // Load transfer: result is ready at once.
         rsp_valid_in = 1'b1;
         rsp_index_in = '0;
         if (full) begin
            count_in      = count_base;
            total_in      = total_base;
            rsp_status_in = wir_pkg::STATUS_FULL;
         end else begin
            count_in      = count_base + (INDEX_BITS + 1)'(1);
            total_in      = sum_sat;
            rsp_status_in = wir_pkg::STATUS_OK;
         end
         rsp_total_in = total_in;
         rsp_count_in = count_in;
      end else if (accept) begin
         pending_in = 1'b1;
      end else if (search_link[INDEX_BITS].valid) begin
         // Draw token left the last cell; set state did not change meanwhile.
         pending_in    = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_index_in  = idx_link[INDEX_BITS];
         rsp_status_in = (count_ff == '0) ? wir_pkg::STATUS_EMPTY : wir_pkg::STATUS_OK;
         rsp_total_in  = total_ff;
         rsp_count_in  = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         total_ff     <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         total_ff     <= total_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_selected_index = rsp_index_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_running_total  = rsp_total_ff;
   assign rsp_loaded_count   = rsp_count_ff;

   // A result never shows while a draw is still in the chain.
   a_no_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("result strobe while draw in flight");

   // A draw transfer returns its result after the full chain latency.
   a_draw_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == wir_pkg::OP_DRAW)) |-> ##(INDEX_BITS + 1) rsp_valid)
      else $error("draw result missing at chain latency");

   // The chosen index is a loaded particle whenever the set is not empty.
   a_index_in_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_loaded_count == '0) || ({1'b0, rsp_selected_index} < rsp_loaded_count)))
      else $error("selected index beyond loaded count");

   // A dropped load only happens with a full store.
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == wir_pkg::STATUS_FULL)) |-> (rsp_loaded_count == COUNT_FULL))
      else $error("load dropped with room in store");

endmodule
